### src/pmad_pkg.sv
// types and constants shared by the power mode arbiter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pmad_pkg;

    typedef enum logic [2:0] {
        DEC_IDLE    = 3'd0,
        DEC_THERMAL = 3'd1,
        DEC_SUPPLY  = 3'd2,
        DEC_AUDIO   = 3'd3,
        DEC_MOTION  = 3'd4
    } decision_t;

    typedef enum logic [2:0] {
        RSN_NONE    = 3'd0,
        RSN_THERMAL = 3'd1,
        RSN_SUPPLY  = 3'd2,
        RSN_AUDIO   = 3'd3,
        RSN_MOTION  = 3'd4,
        RSN_HOLD    = 3'd5
    } reason_t;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH     = 32;
    localparam int CURRENT_WIDTH   = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_INPUT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_CHARGE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DER_CHARGE = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_MS    = 2'd3;

    typedef struct packed {
        logic                      base_input;
        logic [CURRENT_WIDTH-1:0]  max_ma;
        logic [CURRENT_WIDTH-1:0]  der_ma;
        logic [CFG_DATA_WIDTH-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic motion;
        logic audio;
        logic thermal;
        logic supply;
    } req_flags_t;

    typedef struct packed {
        decision_t                prev_decision;
        reason_t                  prev_reason;
        logic                     prev_hold;
        logic                     prev_motion;
        logic [CURRENT_WIDTH-1:0] prev_charge_ma;
        logic                     hold_flag;
        logic [COUNT_WIDTH-1:0]   transitions;
        logic [COUNT_WIDTH-1:0]   grant_entries;
        logic [COUNT_WIDTH-1:0]   derate_entries;
        logic [COUNT_WIDTH-1:0]   block_entries;
    } state_t;

    typedef struct packed {
        decision_t                decision;
        logic                     motion_allowed;
        logic                     wifi_sleep_allowed;
        logic [CURRENT_WIDTH-1:0] charge_current_ma;
        reason_t                  derate_reason;
        logic                     hold_active;
        logic [31:0]              hold_remaining_ms;
        logic [COUNT_WIDTH-1:0]   transition_count;
        logic [COUNT_WIDTH-1:0]   motion_grant_count;
        logic [COUNT_WIDTH-1:0]   derate_entry_count;
        logic [COUNT_WIDTH-1:0]   motion_block_count;
        logic [31:0]              last_transition_ms;
    } result_t;

endpackage

`default_nettype wire

### src/pmad_eval.sv
// single-pass decision, derate and hold evaluation for one item
// depends on pmad_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmad_eval #(
    parameter int TIME_WIDTH = 32
) (
    input  pmad_pkg::cfg_t        cfg,
    input  pmad_pkg::req_flags_t  flags,
    input  logic [TIME_WIDTH-1:0] now_ms,
    input  pmad_pkg::state_t      state,
    input  logic [TIME_WIDTH-1:0] last_load_ms,
    input  logic [TIME_WIDTH-1:0] change_time_ms,
    output pmad_pkg::state_t      state_next,
    output logic [TIME_WIDTH-1:0] last_load_next,
    output logic [TIME_WIDTH-1:0] change_time_next,
    output pmad_pkg::result_t     result
);
    import pmad_pkg::*;

    logic                     load;
    logic [TIME_WIDTH-1:0]    hold_len;
    logic [TIME_WIDTH-1:0]    elapsed;
    logic                     hold_now;
    logic [TIME_WIDTH-1:0]    remaining;
    logic                     derated;
    logic [CURRENT_WIDTH-1:0] charge;
    reason_t                  reason;
    decision_t                dec;
    logic                     allowed;
    logic                     changed;
    logic                     was_blocked;
    logic                     is_blocked;

    always_comb
    begin
        load     = flags.motion | flags.audio;
        hold_len = TIME_WIDTH'(cfg.hold_ms);
        elapsed  = now_ms - last_load_ms;

        if (load)
        begin
            hold_now = (hold_len != '0);
        end
        else if (state.hold_flag && (elapsed >= hold_len))
        begin
            hold_now = 1'b0;
        end
        else
        begin
            hold_now = state.hold_flag;
        end

        // a fresh load restarts the hold, so all of it remains
        if (!hold_now)
        begin
            remaining = '0;
        end
        else if (load)
        begin
            remaining = hold_len;
        end
        else
        begin
            remaining = hold_len - elapsed;
        end

        // derated limit is min(der, max); only derate when it is below max and nonzero
        derated = cfg.base_input
                  && (flags.thermal || flags.supply || load || hold_now)
                  && (cfg.der_ma != '0) && (cfg.der_ma < cfg.max_ma);
        charge  = derated ? cfg.der_ma : cfg.max_ma;

        if (!derated)
        begin
            reason = RSN_NONE;
        end
        else if (flags.thermal)
        begin
            reason = RSN_THERMAL;
        end
        else if (flags.supply)
        begin
            reason = RSN_SUPPLY;
        end
        else if (flags.audio)
        begin
            reason = RSN_AUDIO;
        end
        else if (flags.motion)
        begin
            reason = RSN_MOTION;
        end
        else
        begin
            reason = RSN_HOLD;
        end

        if (flags.thermal)
        begin
            dec = DEC_THERMAL;
        end
        else if (flags.supply)
        begin
            dec = DEC_SUPPLY;
        end
        else if (flags.audio)
        begin
            dec = DEC_AUDIO;
        end
        else if (flags.motion)
        begin
            dec = DEC_MOTION;
        end
        else
        begin
            dec = DEC_IDLE;
        end
        allowed = (dec == DEC_MOTION);

        changed     = (dec != state.prev_decision) || (charge != state.prev_charge_ma)
                      || (reason != state.prev_reason) || (hold_now != state.prev_hold);
        was_blocked = state.prev_motion && (state.prev_decision != DEC_MOTION);
        is_blocked  = flags.motion && !allowed;

        state_next                = state;
        state_next.prev_decision  = dec;
        state_next.prev_reason    = reason;
        state_next.prev_hold      = hold_now;
        state_next.prev_motion    = flags.motion;
        state_next.prev_charge_ma = charge;
        state_next.hold_flag      = hold_now;
        if (changed)
        begin
            state_next.transitions = state.transitions + COUNT_WIDTH'(1);
        end
        if ((state.prev_decision != DEC_MOTION) && allowed)
        begin
            state_next.grant_entries = state.grant_entries + COUNT_WIDTH'(1);
        end
        if ((state.prev_reason == RSN_NONE) && derated)
        begin
            state_next.derate_entries = state.derate_entries + COUNT_WIDTH'(1);
        end
        if (!was_blocked && is_blocked)
        begin
            state_next.block_entries = state.block_entries + COUNT_WIDTH'(1);
        end

        last_load_next   = load ? now_ms : last_load_ms;
        change_time_next = changed ? now_ms : change_time_ms;

        result.decision           = dec;
        result.motion_allowed     = allowed;
        result.wifi_sleep_allowed = (dec == DEC_IDLE);
        result.charge_current_ma  = charge;
        result.derate_reason      = reason;
        result.hold_active        = hold_now;
        result.hold_remaining_ms  = 32'(remaining);
        result.transition_count   = state_next.transitions;
        result.motion_grant_count = state_next.grant_entries;
        result.derate_entry_count = state_next.derate_entries;
        result.motion_block_count = state_next.block_entries;
        result.last_transition_ms = 32'(change_time_next);
    end

endmodule

`default_nettype wire

### src/power_mode_arbiter_with_charge_derate.sv
// top level of the power mode arbiter with charge derating
// holds the input, state, config and result registers; depends on pmad_pkg, pmad_eval
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    now_ms, four request flags
//   out      source     out_valid / out_stall  decision, derate, hold, counters
//   cfg      sink       cfg_wr_en              cfg_index, cfg_wr_data
//
// an accepted item passes through the input register, then one evaluation pass
// into the result register; one item per cycle is sustained while out_stall is low.
// reset clears all state and config as start-up at time zero.
// in_stall rises only while an item waits in the input register and the result
// register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module power_mode_arbiter_with_charge_derate #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [pmad_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pmad_pkg::CFG_DATA_WIDTH-1:0]     cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [TIME_WIDTH-1:0]                   now_ms,
    input  logic                                    motion_requested,
    input  logic                                    audio_busy,
    input  logic                                    thermal_blocked,
    input  logic                                    supply_blocked,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [2:0]                              decision,
    output logic                                    motion_allowed,
    output logic                                    wifi_sleep_allowed,
    output logic [pmad_pkg::CURRENT_WIDTH-1:0]      charge_current_ma,
    output logic [2:0]                              derate_reason,
    output logic                                    hold_active,
    output logic [31:0]                             hold_remaining_ms,
    output logic [pmad_pkg::COUNT_WIDTH-1:0]        transition_count,
    output logic [pmad_pkg::COUNT_WIDTH-1:0]        motion_grant_count,
    output logic [pmad_pkg::COUNT_WIDTH-1:0]        derate_entry_count,
    output logic [pmad_pkg::COUNT_WIDTH-1:0]        motion_block_count,
    output logic [31:0]                             last_transition_ms
);
    import pmad_pkg::*;

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] in_now_reg;
    req_flags_t            in_flags_reg;
    state_t                state_reg;
    state_t                state_next;
    logic [TIME_WIDTH-1:0] last_load_reg;
    logic [TIME_WIDTH-1:0] last_load_next;
    logic [TIME_WIDTH-1:0] change_time_reg;
    logic [TIME_WIDTH-1:0] change_time_next;
    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               result_next;
    logic                  out_ready;
    logic                  advance;
    logic                  in_accept;

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BASE_INPUT: cfg_reg.base_input <= cfg_wr_data[0];
                CFG_MAX_CHARGE: cfg_reg.max_ma     <= cfg_wr_data[CURRENT_WIDTH-1:0];
                CFG_DER_CHARGE: cfg_reg.der_ma     <= cfg_wr_data[CURRENT_WIDTH-1:0];
                CFG_HOLD_MS:    cfg_reg.hold_ms    <= cfg_wr_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_now_reg           <= now_ms;
            in_flags_reg.motion  <= motion_requested;
            in_flags_reg.audio   <= audio_busy;
            in_flags_reg.thermal <= thermal_blocked;
            in_flags_reg.supply  <= supply_blocked;
        end
    end

    pmad_eval #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_eval (
        .cfg              (cfg_reg),
        .flags            (in_flags_reg),
        .now_ms           (in_now_reg),
        .state            (state_reg),
        .last_load_ms     (last_load_reg),
        .change_time_ms   (change_time_reg),
        .state_next       (state_next),
        .last_load_next   (last_load_next),
        .change_time_next (change_time_next),
        .result           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            last_load_reg   <= '0;
            change_time_reg <= '0;
        end
        else if (advance)
        begin
            state_reg       <= state_next;
            last_load_reg   <= last_load_next;
            change_time_reg <= change_time_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign decision           = out_reg.decision;
    assign motion_allowed     = out_reg.motion_allowed;
    assign wifi_sleep_allowed = out_reg.wifi_sleep_allowed;
    assign charge_current_ma  = out_reg.charge_current_ma;
    assign derate_reason      = out_reg.derate_reason;
    assign hold_active        = out_reg.hold_active;
    assign hold_remaining_ms  = out_reg.hold_remaining_ms;
    assign transition_count   = out_reg.transition_count;
    assign motion_grant_count = out_reg.motion_grant_count;
    assign derate_entry_count = out_reg.derate_entry_count;
    assign motion_block_count = out_reg.motion_block_count;
    assign last_transition_ms = out_reg.last_transition_ms;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled while the result register can take an item");

    a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) && !in_valid_reg |=> !out_valid_reg)
        else $error("result shown with no item in the input register");

    a_no_hold_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.hold_active |-> (out_reg.hold_remaining_ms == '0))
        else $error("hold time left reported while hold is inactive");

    a_grant_matches_decision: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.motion_allowed == (out_reg.decision == DEC_MOTION))
                          && !(out_reg.motion_allowed && out_reg.wifi_sleep_allowed))
        else $error("motion grant inconsistent with decision");
`endif

endmodule

`default_nettype wire

### test/tb_power_mode_arbiter_with_charge_derate.sv
// self-checking bench for power_mode_arbiter_with_charge_derate: directed and random requests,
// predicted results compared field by field; depends on pmad_pkg and the arbiter rtl
`timescale 1ns / 1ps

module tb_power_mode_arbiter_with_charge_derate;

    import pmad_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD   = 64;

    typedef struct packed {
        logic [31:0] now;
        req_flags_t  flags;
    } request_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [31:0]                now_ms = '0;
    logic                       motion_requested = 1'b0;
    logic                       audio_busy = 1'b0;
    logic                       thermal_blocked = 1'b0;
    logic                       supply_blocked = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [2:0]                 decision;
    logic                       motion_allowed;
    logic                       wifi_sleep_allowed;
    logic [CURRENT_WIDTH-1:0]   charge_current_ma;
    logic [2:0]                 derate_reason;
    logic                       hold_active;
    logic [31:0]                hold_remaining_ms;
    logic [COUNT_WIDTH-1:0]     transition_count;
    logic [COUNT_WIDTH-1:0]     motion_grant_count;
    logic [COUNT_WIDTH-1:0]     derate_entry_count;
    logic [COUNT_WIDTH-1:0]     motion_block_count;
    logic [31:0]                last_transition_ms;

    power_mode_arbiter_with_charge_derate i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .now_ms             (now_ms),
        .motion_requested   (motion_requested),
        .audio_busy         (audio_busy),
        .thermal_blocked    (thermal_blocked),
        .supply_blocked     (supply_blocked),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .decision           (decision),
        .motion_allowed     (motion_allowed),
        .wifi_sleep_allowed (wifi_sleep_allowed),
        .charge_current_ma  (charge_current_ma),
        .derate_reason      (derate_reason),
        .hold_active        (hold_active),
        .hold_remaining_ms  (hold_remaining_ms),
        .transition_count   (transition_count),
        .motion_grant_count (motion_grant_count),
        .derate_entry_count (derate_entry_count),
        .motion_block_count (motion_block_count),
        .last_transition_ms (last_transition_ms)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // arbiter copy: config and state
    logic                     base_mode = 1'b0;
    logic [CURRENT_WIDTH-1:0] max_ma = '0;
    logic [CURRENT_WIDTH-1:0] der_ma = '0;
    logic [31:0]              hold_ms = '0;

    decision_t                last_decision = DEC_IDLE;
    reason_t                  last_reason = RSN_NONE;
    logic                     last_hold = 1'b0;
    logic                     last_motion = 1'b0;
    logic [CURRENT_WIDTH-1:0] last_charge = '0;
    logic                     hold_on = 1'b0;
    logic [31:0]              load_time = '0;
    logic [31:0]              n_transitions = '0;
    logic [31:0]              n_grants = '0;
    logic [31:0]              n_derates = '0;
    logic [31:0]              n_blocks = '0;
    logic [31:0]              change_time = '0;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       errors = 0;
    logic     item_taken = 1'b0;
    logic     quiet = 1'b0;
    logic     long_hold_req = 1'b0;
    logic [31:0] clock_ms = '0;

    function automatic result_t arbitrate(request_t rq);
        result_t                  r;
        logic                     load;
        logic [31:0]              elapsed;
        logic [31:0]              remaining;
        logic [CURRENT_WIDTH-1:0] eff;
        logic [CURRENT_WIDTH-1:0] charge;
        logic                     derated;
        logic                     changed;
        logic                     was_blocked;
        logic                     is_blocked;
        decision_t                dec;
        reason_t                  rsn;

        load = rq.flags.motion | rq.flags.audio;
        if (load)
        begin
            load_time = rq.now;
            hold_on = (hold_ms != 0);
        end
        else if (hold_on && (rq.now - load_time) >= hold_ms)
        begin
            hold_on = 1'b0;
        end
        remaining = '0;
        if (hold_on)
        begin
            elapsed = rq.now - load_time;
            remaining = (elapsed < hold_ms) ? hold_ms - elapsed : '0;
        end

        eff = (der_ma < max_ma) ? der_ma : max_ma;
        derated = base_mode && (rq.flags.thermal || rq.flags.supply || load || hold_on)
                  && eff != 0 && eff < max_ma;
        charge = derated ? eff : max_ma;

        if (!derated)              rsn = RSN_NONE;
        else if (rq.flags.thermal) rsn = RSN_THERMAL;
        else if (rq.flags.supply)  rsn = RSN_SUPPLY;
        else if (rq.flags.audio)   rsn = RSN_AUDIO;
        else if (rq.flags.motion)  rsn = RSN_MOTION;
        else                       rsn = RSN_HOLD;

        if (rq.flags.thermal)     dec = DEC_THERMAL;
        else if (rq.flags.supply) dec = DEC_SUPPLY;
        else if (rq.flags.audio)  dec = DEC_AUDIO;
        else if (rq.flags.motion) dec = DEC_MOTION;
        else                      dec = DEC_IDLE;

        changed = dec != last_decision || charge != last_charge || rsn != last_reason
                  || hold_on != last_hold;
        was_blocked = last_motion && last_decision != DEC_MOTION;
        is_blocked = rq.flags.motion && dec != DEC_MOTION;

        if (changed)
        begin
            n_transitions = n_transitions + 1;
            change_time = rq.now;
        end
        if (last_decision != DEC_MOTION && dec == DEC_MOTION)
            n_grants = n_grants + 1;
        if (last_reason == RSN_NONE && derated)
            n_derates = n_derates + 1;
        if (!was_blocked && is_blocked)
            n_blocks = n_blocks + 1;

        last_motion = rq.flags.motion;
        last_decision = dec;
        last_reason = rsn;
        last_hold = hold_on;
        last_charge = charge;

        r.decision = dec;
        r.motion_allowed = (dec == DEC_MOTION);
        r.wifi_sleep_allowed = (dec == DEC_IDLE);
        r.charge_current_ma = charge;
        r.derate_reason = rsn;
        r.hold_active = hold_on;
        r.hold_remaining_ms = remaining;
        r.transition_count = n_transitions;
        r.motion_grant_count = n_grants;
        r.derate_entry_count = n_derates;
        r.motion_block_count = n_blocks;
        r.last_transition_ms = change_time;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        result_t  exp_r;
        request_t seen;

        item_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_BASE_INPUT: base_mode = cfg_wr_data[0];
                    CFG_MAX_CHARGE: max_ma = cfg_wr_data[CURRENT_WIDTH-1:0];
                    CFG_DER_CHARGE: der_ma = cfg_wr_data[CURRENT_WIDTH-1:0];
                    CFG_HOLD_MS:    hold_ms = cfg_wr_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no item pending, decision %0h", $time, decision);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("decision", exp_r.decision, decision);
                    check_field("motion_allowed", exp_r.motion_allowed, motion_allowed);
                    check_field("wifi_sleep_allowed", exp_r.wifi_sleep_allowed,
                                wifi_sleep_allowed);
                    check_field("charge_current_ma", exp_r.charge_current_ma,
                                charge_current_ma);
                    check_field("derate_reason", exp_r.derate_reason, derate_reason);
                    check_field("hold_active", exp_r.hold_active, hold_active);
                    check_field("hold_remaining_ms", exp_r.hold_remaining_ms,
                                hold_remaining_ms);
                    check_field("transition_count", exp_r.transition_count,
                                transition_count);
                    check_field("motion_grant_count", exp_r.motion_grant_count,
                                motion_grant_count);
                    check_field("derate_entry_count", exp_r.derate_entry_count,
                                derate_entry_count);
                    check_field("motion_block_count", exp_r.motion_block_count,
                                motion_block_count);
                    check_field("last_transition_ms", exp_r.last_transition_ms,
                                last_transition_ms);
                end
            end
            if (in_valid && !in_stall)
            begin
                item_taken = 1'b1;
                seen.now = now_ms;
                seen.flags.motion = motion_requested;
                seen.flags.audio = audio_busy;
                seen.flags.thermal = thermal_blocked;
                seen.flags.supply = supply_blocked;
                expected_results.push_back(arbitrate(seen));
            end
        end
    end

    // driver
    int       send_gap = 0;
    request_t next_rq;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || item_taken))
        begin
            if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 5);
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_rq = pending_requests.pop_front();
                in_valid <= 1'b1;
                now_ms <= next_rq.now;
                motion_requested <= next_rq.flags.motion;
                audio_busy <= next_rq.flags.audio;
                thermal_blocked <= next_rq.flags.thermal;
                supply_blocked <= next_rq.flags.supply;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    int stall_left = 0;
    int long_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_left = LONG_HOLD;
            end
            if (long_left > 0)
            begin
                long_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    int stuck = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck = 0;
        else
            stuck++;
        if (stuck == STUCK_LIMIT)
        begin
            $display("[power_mode_arbiter_with_charge_derate] ERROR");
            $finish;
        end
    end

    task automatic push(logic [31:0] t, logic m, logic a, logic th, logic sp);
        request_t rq;
        rq.now = t;
        rq.flags.motion = m;
        rq.flags.audio = a;
        rq.flags.thermal = th;
        rq.flags.supply = sp;
        pending_requests.push_back(rq);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(logic base, logic [15:0] max_c, logic [15:0] der_c,
                             logic [31:0] hold_c);
        write_reg(CFG_BASE_INPUT, {31'd0, base});
        write_reg(CFG_MAX_CHARGE, {16'd0, max_c});
        write_reg(CFG_DER_CHARGE, {16'd0, der_c});
        write_reg(CFG_HOLD_MS, hold_c);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_random(int count, int span);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                clock_ms = $urandom;
            else if (pick == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
            else if (pick > 3)
                clock_ms = clock_ms + $urandom_range(0, span);
            push(clock_ms, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0,
                 $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin
        int span;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // start-up with all registers at zero
        push(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        configure(1'b1, 16'd1000, 16'd300, 32'd50);
        push(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'd10, 1'b0, 1'b0, 1'b1, 1'b0);
        push(32'd20, 1'b0, 1'b0, 1'b0, 1'b1);
        push(32'd30, 1'b0, 1'b1, 1'b0, 1'b0);
        push(32'd40, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'd45, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'd79, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'd80, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'd100, 1'b1, 1'b0, 1'b0, 1'b0);
        push(32'd101, 1'b1, 1'b0, 1'b1, 1'b0);
        push(32'd102, 1'b1, 1'b1, 1'b1, 1'b1);
        push(32'd103, 1'b1, 1'b0, 1'b0, 1'b0);
        // hold across the time wrap
        push(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0, 1'b0);
        push(32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'h0000_0030, 1'b0, 1'b0, 1'b0, 1'b0);
        push(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0);
        push(32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // derated limit equal to max, hold disabled
        configure(1'b1, 16'd1000, 16'd1000, 32'd0);
        push(32'd5, 1'b1, 1'b0, 1'b0, 1'b0);
        push(32'd6, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // derated limit zero
        configure(1'b1, 16'd1000, 16'd0, 32'd50);
        push(32'd7, 1'b0, 1'b1, 1'b0, 1'b0);
        wait_idle();

        // not on base input
        configure(1'b0, 16'd1000, 16'd300, 32'd50);
        push(32'd8, 1'b0, 1'b0, 1'b1, 1'b1);
        push(32'd9, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            span = 40;
            case (p)
                0: configure(1'b1, 16'd2000, 16'd500, $urandom_range(10, 200));
                1: configure(1'b0, 16'd2000, 16'd500, 32'd100);
                2: configure(1'b1, 16'hFFFF, 16'hFFFE, 32'd0);
                3: configure(1'b1, 16'd100, 16'd100, 32'd80);
                4:
                begin
                    configure(1'b1, 16'd0, 16'd0, 32'hFFFF_FFFF);
                    span = 1000;
                end
                5:
                begin
                    configure(1'b1, 16'hFFFF, 16'd0, 32'd1);
                    span = 3;
                end
                6: configure(1'b1, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), $urandom_range(1, 300));
                default:
                begin
                    configure(1'b1, 16'd3000, 16'd1, 32'd64);
                    quiet = 1'b1;
                end
            endcase
            queue_random(200, span);
            if (p == 3)
                long_hold_req = 1'b1;
            wait_idle();
        end

        if (errors == 0)
            $display("[power_mode_arbiter_with_charge_derate] OK");
        else
            $display("[power_mode_arbiter_with_charge_derate] ERROR");
        $finish;
    end

endmodule
